// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: action codes,
// decoded command kinds and the command word passed from front to back.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int POS_W    = 12;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CURSOR_W = 11;

    localparam logic [CHAR_W-1:0] NEWLINE_CHAR       = 8'd10;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'd15;

    localparam logic [1:0] ACT_WRITE_CURSOR = 2'd0;
    localparam logic [1:0] ACT_WRITE_AT     = 2'd1;
    localparam logic [1:0] ACT_CLEAR        = 2'd2;
    localparam logic [1:0] ACT_READ         = 2'd3;

    typedef enum logic [2:0] {
        CMD_PUT_CUR = 3'd0,
        CMD_PUT_POS = 3'd1,
        CMD_NL_CUR  = 3'd2,
        CMD_NL_POS  = 3'd3,
        CMD_CLEAR   = 3'd4,
        CMD_READ    = 3'd5,
        CMD_REJECT  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  character;
        logic [ATTR_W-1:0]  attribute;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
        logic [POS_W-1:0]   pos;
    } t_cmd;

endpackage

// ----- rtl/core/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text console of ROWS x COLUMNS character/attribute cells with a cursor.
//
// Channel   Direction  Handshake                   Payload
// config    in         i_cfg_wr_en                 i_cfg_wr_data
// item      in         i_in_valid / o_in_ready     action, character, row,
//                                                  column, attribute
// result    out        o_out_valid / i_out_ready   cursor_position,
//                                                  read_character,
//                                                  read_attribute, scrolled,
//                                                  status
//
// Character write, newline and rejected position: straight to the result register.
// Cell read: registered read of the cell store, then the result register.
// Scroll copies rows up and blanks the last row, clear zeroes the characters,
// a cell at a time. After reset the cell store is zeroed, o_in_ready low.
// A two-entry queue lets the input side keep taking items while the back
// stage sweeps or the result register waits.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ATTR_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic [CHAR_W-1:0]   i_character,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [COL_W-1:0]    i_column,
    input  logic [ATTR_W-1:0]   i_attribute,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CURSOR_W-1:0] o_cursor_position,
    output logic [CHAR_W-1:0]   o_read_character,
    output logic [ATTR_W-1:0]   o_read_attribute,
    output logic                o_scrolled,
    output logic                o_status
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic back_ready;
    t_cmd front_cmd;
    t_cmd head_cmd;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_character   (i_character),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_attribute   (i_attribute),
        .i_back_ready  (back_ready),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_cmd             (head_cmd),
        .o_pop             (pop),
        .o_ready           (back_ready),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cursor_position (o_cursor_position),
        .o_read_character  (o_read_character),
        .o_read_attribute  (o_read_attribute),
        .o_scrolled        (o_scrolled),
        .o_status          (o_status)
    );

endmodule

// ----- rtl/core/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Input stage: holds the default attribute, checks positions, resolves the
// attribute and turns each accepted item into a command for the queue.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ATTR_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [CHAR_W-1:0] i_character,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_column,
    input  logic [ATTR_W-1:0] i_attribute,
    input  logic              i_back_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [ATTR_W-1:0] r_default_attr;
    logic              in_range;
    logic              is_newline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_attr <= DEFAULT_ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_default_attr <= i_cfg_wr_data;
        end
    end

    assign in_range   = ({1'b0, i_row} < (ROW_W + 1)'(ROWS))
                     && ({1'b0, i_column} < (COL_W + 1)'(COLUMNS));
    assign is_newline = (i_character == NEWLINE_CHAR);
    assign o_in_ready = i_back_ready && !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.character = i_character;
        o_cmd.attribute = (i_attribute == '0) ? r_default_attr : i_attribute;
        o_cmd.row       = i_row;
        o_cmd.column    = i_column;
        o_cmd.pos       = POS_W'(i_row) * POS_W'(COLUMNS) + POS_W'(i_column);
        case (i_action)
            ACT_WRITE_CURSOR: o_cmd.kind = is_newline ? CMD_NL_CUR : CMD_PUT_CUR;
            ACT_WRITE_AT: begin
                if (!in_range) begin
                    o_cmd.kind = CMD_REJECT;
                end else begin
                    o_cmd.kind = is_newline ? CMD_NL_POS : CMD_PUT_POS;
                end
            end
            ACT_CLEAR:        o_cmd.kind = CMD_CLEAR;
            ACT_READ:         o_cmd.kind = in_range ? CMD_READ : CMD_REJECT;
            default:          o_cmd.kind = CMD_REJECT;
        endcase
    end

endmodule

// ----- rtl/core/tcw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front and back stages.
// ----------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int DEPTH = 2;

    t_cmd                       r_slot [DEPTH];
    logic [$clog2(DEPTH)-1:0]   r_wr_ptr;
    logic [$clog2(DEPTH)-1:0]   r_rd_ptr;
    logic [$clog2(DEPTH+1)-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == ($clog2(DEPTH+1))'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

endmodule

// ----- rtl/core/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Execution stage: owns the cell store and the cursor, runs writes, reads,
// scroll and clear sweeps, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    output logic                o_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [CURSOR_W-1:0] o_cursor_position,
    output logic [CHAR_W-1:0]   o_read_character,
    output logic [ATTR_W-1:0]   o_read_attribute,
    output logic                o_scrolled,
    output logic                o_status
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int COPY_N     = CELL_COUNT - COLUMNS;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_BLANK  = 6'b010000,
        ST_CLEAR  = 6'b100000
    } t_state;

    logic [CHAR_W-1:0] r_char_mem [CELL_COUNT];
    logic [ATTR_W-1:0] r_attr_mem [CELL_COUNT];
    logic [CHAR_W-1:0] r_rd_char;
    logic [ATTR_W-1:0] r_rd_attr;

    t_state  r_state,   n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_cur_row, n_cur_row;
    logic [CW-1:0] r_cur_col, n_cur_col;
    logic [AW-1:0] r_cur_idx, n_cur_idx;

    logic                r_out_valid, n_out_valid;
    logic [CURSOR_W-1:0] r_out_cursor, n_out_cursor;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic [ATTR_W-1:0]   r_out_attr, n_out_attr;
    logic                r_out_scrolled, n_out_scrolled;
    logic                r_out_status, n_out_status;

    logic              we_char;
    logic              we_attr;
    logic [AW-1:0]     wr_addr;
    logic [CHAR_W-1:0] wr_char;
    logic [ATTR_W-1:0] wr_attr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic          out_free;
    logic          at_pos;
    logic          is_nl;
    logic [RW-1:0] t_row;
    logic [CW-1:0] t_col;
    logic [AW-1:0] t_pos;
    logic          wrap;
    logic          scroll;
    logic [RW-1:0] mv_row;
    logic [CW-1:0] mv_col;
    logic [AW-1:0] mv_idx;

    always_ff @(posedge i_clk) begin
        if (we_char) begin
            r_char_mem[wr_addr] <= wr_char;
        end
        if (we_attr) begin
            r_attr_mem[wr_addr] <= wr_attr;
        end
        if (rd_en) begin
            r_rd_char <= r_char_mem[rd_addr];
            r_rd_attr <= r_attr_mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign at_pos   = (i_cmd.kind == CMD_PUT_POS) || (i_cmd.kind == CMD_NL_POS);
    assign is_nl    = (i_cmd.kind == CMD_NL_CUR) || (i_cmd.kind == CMD_NL_POS);
    assign t_row    = at_pos ? i_cmd.row[RW-1:0]    : r_cur_row;
    assign t_col    = at_pos ? i_cmd.column[CW-1:0] : r_cur_col;
    assign t_pos    = at_pos ? i_cmd.pos[AW-1:0]    : r_cur_idx;
    assign wrap     = is_nl || (t_col == CW'(COLUMNS - 1));
    assign scroll   = wrap && (t_row == RW'(ROWS - 1));

    always_comb begin
        if (scroll) begin
            mv_row = RW'(ROWS - 1);
            mv_col = '0;
            mv_idx = AW'(COPY_N);
        end else if (wrap) begin
            mv_row = t_row + 1'b1;
            mv_col = '0;
            mv_idx = is_nl ? (t_pos - AW'(t_col) + AW'(COLUMNS)) : (t_pos + 1'b1);
        end else begin
            mv_row = t_row;
            mv_col = t_col + 1'b1;
            mv_idx = t_pos + 1'b1;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_cur_row      = r_cur_row;
        n_cur_col      = r_cur_col;
        n_cur_idx      = r_cur_idx;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_cursor   = r_out_cursor;
        n_out_char     = r_out_char;
        n_out_attr     = r_out_attr;
        n_out_scrolled = r_out_scrolled;
        n_out_status   = r_out_status;
        we_char        = 1'b0;
        we_attr        = 1'b0;
        wr_addr        = r_cnt;
        wr_char        = '0;
        wr_attr        = '0;
        rd_en          = 1'b0;
        rd_addr        = t_pos;
        o_pop          = 1'b0;

        case (r_state)
            ST_INIT: begin
                we_char = 1'b1;
                we_attr = 1'b1;
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop          = 1'b1;
                    n_out_char     = '0;
                    n_out_attr     = '0;
                    n_out_scrolled = 1'b0;
                    n_out_status   = 1'b0;
                    case (i_cmd.kind)
                        CMD_PUT_CUR, CMD_PUT_POS, CMD_NL_CUR, CMD_NL_POS: begin
                            if (!is_nl) begin
                                we_char = 1'b1;
                                we_attr = 1'b1;
                                wr_addr = t_pos;
                                wr_char = i_cmd.character;
                                wr_attr = i_cmd.attribute;
                            end
                            n_cur_row = mv_row;
                            n_cur_col = mv_col;
                            n_cur_idx = mv_idx;
                            if (scroll) begin
                                n_cnt   = '0;
                                n_state = ST_SCROLL;
                            end else begin
                                n_out_valid  = 1'b1;
                                n_out_cursor = CURSOR_W'(mv_idx);
                            end
                        end
                        CMD_CLEAR: begin
                            n_cur_row = '0;
                            n_cur_col = '0;
                            n_cur_idx = '0;
                            n_cnt     = '0;
                            n_state   = ST_CLEAR;
                        end
                        CMD_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = i_cmd.pos[AW-1:0];
                            n_state = ST_READ;
                        end
                        default: begin
                            n_out_valid  = 1'b1;
                            n_out_cursor = CURSOR_W'(r_cur_idx);
                            n_out_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_out_valid  = 1'b1;
                n_out_cursor = CURSOR_W'(r_cur_idx);
                n_out_char   = r_rd_char;
                n_out_attr   = r_rd_attr;
                n_state      = ST_IDLE;
            end
            ST_SCROLL: begin
                if (r_cnt != AW'(COPY_N)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt + AW'(COLUMNS);
                end
                if (r_cnt != '0) begin
                    we_char = 1'b1;
                    we_attr = 1'b1;
                    wr_addr = r_cnt - 1'b1;
                    wr_char = r_rd_char;
                    wr_attr = r_rd_attr;
                end
                if (r_cnt == AW'(COPY_N)) begin
                    n_state = ST_BLANK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BLANK: begin
                we_char = 1'b1;
                we_attr = 1'b1;
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_out_valid    = 1'b1;
                    n_out_cursor   = CURSOR_W'(r_cur_idx);
                    n_out_scrolled = 1'b1;
                    n_cnt          = '0;
                    n_state        = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CLEAR: begin
                we_char = 1'b1;
                if (r_cnt == AW'(CELL_COUNT - 1)) begin
                    n_out_valid  = 1'b1;
                    n_out_cursor = CURSOR_W'(r_cur_idx);
                    n_cnt        = '0;
                    n_state      = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_cnt   = '0;
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cur_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_cur_idx   <= n_cur_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cursor   <= n_out_cursor;
        r_out_char     <= n_out_char;
        r_out_attr     <= n_out_attr;
        r_out_scrolled <= n_out_scrolled;
        r_out_status   <= n_out_status;
    end

    assign o_ready           = (r_state != ST_INIT);
    assign o_out_valid       = r_out_valid;
    assign o_cursor_position = r_out_cursor;
    assign o_read_character  = r_out_char;
    assign o_read_attribute  = r_out_attr;
    assign o_scrolled        = r_out_scrolled;
    assign o_status          = r_out_status;

endmodule

// ----- rtl/core/tcw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer result channel.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [CURSOR_W-1:0] i_cursor_position,
    input  logic [CHAR_W-1:0]   i_read_character,
    input  logic [ATTR_W-1:0]   i_read_attribute,
    input  logic                i_scrolled,
    input  logic                i_status
);

    localparam int SCROLL_POS = (ROWS - 1) * COLUMNS;

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_reject_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |->
            i_read_character == '0 && i_read_attribute == '0 && !i_scrolled)
        else $error("rejected item carries data or scroll");

    a_scroll_cursor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_scrolled |-> i_cursor_position == CURSOR_W'(SCROLL_POS))
        else $error("scroll left cursor off the last row start");

    a_read_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_read_character != '0 || i_read_attribute != '0) |->
            !i_scrolled && !i_status)
        else $error("read data on a non-read result");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .i_cursor_position (o_cursor_position),
    .i_read_character  (o_read_character),
    .i_read_attribute  (o_read_attribute),
    .i_scrolled        (o_scrolled),
    .i_status          (o_status)
);

// ----- tb/text_console_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the configuration, item and result channels of the text console
// writer. It keeps its own copy of the screen, the cursor and the default
// attribute, works out the result of every accepted item, and compares each
// result transfer field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module text_console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ATTR_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_action,
    input  logic [CHAR_W-1:0]   i_character,
    input  logic [ROW_W-1:0]    i_row,
    input  logic [COL_W-1:0]    i_column,
    input  logic [ATTR_W-1:0]   i_attribute,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [CURSOR_W-1:0] i_cursor_position,
    input  logic [CHAR_W-1:0]   i_read_character,
    input  logic [ATTR_W-1:0]   i_read_attribute,
    input  logic                i_scrolled,
    input  logic                i_status,
    output int                  o_mismatch_count,
    output int                  o_replies_owed
);

    localparam int CELLS = ROWS * COLUMNS;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CHAR_W-1:0]   character;
        logic [ATTR_W-1:0]   attribute;
        logic                scrolled;
        logic                status;
    } t_reply;

    logic [ATTR_W+CHAR_W-1:0] screen [CELLS];
    int unsigned              cursor_cell;
    logic [ATTR_W-1:0]        default_attr;
    t_reply                   replies_q [$];

    // Move the cursor on; scroll up one row when it runs off the screen.
    function automatic logic advance_cursor(int unsigned next);
        if (next < CELLS) begin
            cursor_cell = next;
            return 1'b0;
        end
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = '0;
        end
        cursor_cell = next - COLUMNS;
        return 1'b1;
    endfunction

    function automatic logic place_glyph(int unsigned spot, logic [CHAR_W-1:0] ch,
                                         logic [ATTR_W-1:0] attr);
        if (ch == NEWLINE_CHAR) begin
            return advance_cursor((spot / COLUMNS + 1) * COLUMNS);
        end
        screen[spot] = {(attr == '0) ? default_attr : attr, ch};
        return advance_cursor(spot + 1);
    endfunction

    function automatic t_reply console_step(logic [1:0] action, logic [CHAR_W-1:0] ch,
                                            logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                            logic [ATTR_W-1:0] attr);
        t_reply      reply;
        logic        in_range;
        int unsigned spot;
        reply    = '0;
        in_range = (row < ROWS) && (col < COLUMNS);
        spot     = row * COLUMNS + col;
        case (action)
            ACT_WRITE_CURSOR: begin
                reply.scrolled = place_glyph(cursor_cell, ch, attr);
            end
            ACT_WRITE_AT: begin
                if (in_range) begin
                    reply.scrolled = place_glyph(spot, ch, attr);
                end else begin
                    reply.status = 1'b1;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i][CHAR_W-1:0] = '0;
                end
                cursor_cell = 0;
            end
            default: begin
                if (in_range) begin
                    reply.character = screen[spot][CHAR_W-1:0];
                    reply.attribute = screen[spot][ATTR_W+CHAR_W-1:CHAR_W];
                end else begin
                    reply.status = 1'b1;
                end
            end
        endcase
        reply.cursor = cursor_cell[CURSOR_W-1:0];
        return reply;
    endfunction

    task automatic compare_field(string field, int unsigned wanted, int unsigned seen);
        if (wanted != seen) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, wanted,
                     seen);
            o_mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_reply wanted;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = '0;
            end
            cursor_cell  = 0;
            default_attr = DEFAULT_ATTR_RESET;
            replies_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (replies_q.size() == 0) begin
                    $display("%0t ns: result transfer with none outstanding, actual cursor %0d",
                             $time, i_cursor_position);
                    o_mismatch_count++;
                end else begin
                    wanted = replies_q.pop_front();
                    compare_field("cursor_position", 32'(wanted.cursor),
                                  32'(i_cursor_position));
                    compare_field("read_character", 32'(wanted.character),
                                  32'(i_read_character));
                    compare_field("read_attribute", 32'(wanted.attribute),
                                  32'(i_read_attribute));
                    compare_field("scrolled", 32'(wanted.scrolled), 32'(i_scrolled));
                    compare_field("status", 32'(wanted.status), 32'(i_status));
                end
            end
            if (i_cfg_wr_en) begin
                default_attr = i_cfg_wr_data;
            end
            if (i_in_valid && i_in_ready) begin
                replies_q.push_back(console_step(i_action, i_character, i_row, i_column,
                                                 i_attribute));
            end
        end
        o_replies_owed <= replies_q.size();
    end

endmodule

// ----- tb/tb_text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives the text console writer with a directed pass over the corner cases
// (scroll at the last cell and on a last-row newline, out-of-range positions,
// clear keeping attributes, default attribute) and then phases of random
// text lines, newline bursts, positioned writes with read-back, clears and
// noise, each phase under a new default attribute. Both channels stall at
// random; one phase runs without stalls and one holds the result side off.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLUMNS         = 80;
    localparam int ROWS            = 25;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_PCT        = 21;
    localparam int PHASES          = 6;
    localparam int PHASE_ITEMS     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT  = 50000;
    localparam int RECENT_DEPTH    = 32;
    localparam int ROW_MAX         = (1 << ROW_W) - 1;
    localparam int COL_MAX         = (1 << COL_W) - 1;

    localparam logic [ROW_W-1:0] ROW_TOP   = ROW_W'(ROW_MAX);
    localparam logic [COL_W-1:0] COL_TOP   = COL_W'(COL_MAX);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ROW_W-1:0] ROW_PREV  = ROW_W'(ROWS - 2);
    localparam logic [ROW_W-1:0] ROW_PAST  = ROW_W'(ROWS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0] COL_PAST  = COL_W'(COLUMNS);

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [ATTR_W-1:0]   i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_action;
    logic [CHAR_W-1:0]   i_character;
    logic [ROW_W-1:0]    i_row;
    logic [COL_W-1:0]    i_column;
    logic [ATTR_W-1:0]   i_attribute;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [CURSOR_W-1:0] o_cursor_position;
    logic [CHAR_W-1:0]   o_read_character;
    logic [ATTR_W-1:0]   o_read_attribute;
    logic                o_scrolled;
    logic                o_status;

    int mismatch_count;
    int replies_owed;
    int items_sent;
    bit quiet_phase;
    bit hold_off_req;
    bit hold_off_done;

    logic [ROW_W+COL_W-1:0] written_spots [$];

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_character      (i_character),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_attribute      (i_attribute),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_position(o_cursor_position),
        .o_read_character (o_read_character),
        .o_read_attribute (o_read_attribute),
        .o_scrolled       (o_scrolled),
        .o_status         (o_status)
    );

    text_console_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_console_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_character      (i_character),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_attribute      (i_attribute),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_cursor_position(o_cursor_position),
        .i_read_character (o_read_character),
        .i_read_attribute (o_read_attribute),
        .i_scrolled       (o_scrolled),
        .i_status         (o_status),
        .o_mismatch_count (mismatch_count),
        .o_replies_owed   (replies_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [ROW_W-1:0] any_row();
        return ROW_W'($urandom_range(0, ROW_MAX));
    endfunction

    function automatic logic [COL_W-1:0] any_column();
        return COL_W'($urandom_range(0, COL_MAX));
    endfunction

    function automatic logic [CHAR_W-1:0] any_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ROW_W-1:0] pick_row();
        return ($urandom_range(0, 9) == 0) ? any_row()
                                           : ROW_W'($urandom_range(0, ROWS - 1));
    endfunction

    function automatic logic [COL_W-1:0] pick_column();
        return ($urandom_range(0, 9) == 0) ? any_column()
                                           : COL_W'($urandom_range(0, COLUMNS - 1));
    endfunction

    function automatic logic [ATTR_W-1:0] pick_attribute();
        return ($urandom_range(0, 3) == 0) ? '0 : any_byte();
    endfunction

    function automatic logic [CHAR_W-1:0] pick_glyph();
        return ($urandom_range(0, 19) == 0) ? NEWLINE_CHAR : any_byte();
    endfunction

    task automatic send_command(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                                input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                                input logic [ATTR_W-1:0] attr);
        @(negedge i_clk);
        while (!quiet_phase && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_action    <= act;
        i_character <= ch;
        i_row       <= row;
        i_column    <= col;
        i_attribute <= attr;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (act == ACT_WRITE_AT && row < ROWS && col < COLUMNS) begin
            written_spots.push_back({row, col});
            if (written_spots.size() > RECENT_DEPTH) begin
                void'(written_spots.pop_front());
            end
        end
    endtask

    // Drop valid, wait for every result, then load the register.
    task automatic write_default_attribute(input logic [ATTR_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (replies_owed == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_directed();
        send_command(ACT_READ, 8'h00, 0, 0, 8'h00);
        send_command(ACT_WRITE_CURSOR, 8'h41, ROW_TOP, COL_TOP, 8'h00);
        send_command(ACT_WRITE_CURSOR, 8'hFF, 0, 0, 8'hFF);
        send_command(ACT_WRITE_CURSOR, 8'h00, 0, 0, 8'h01);
        send_command(ACT_WRITE_CURSOR, NEWLINE_CHAR, 0, 0, 8'h5A);
        send_command(ACT_READ, 8'hFF, 0, 0, 8'hFF);
        send_command(ACT_READ, 8'h00, 0, 2, 8'h00);
        send_command(ACT_WRITE_AT, 8'h7E, ROW_LAST, COL_LAST, 8'h80);
        send_command(ACT_READ, 8'h00, ROW_PREV, COL_LAST, 8'h00);
        send_command(ACT_READ, 8'h00, ROW_LAST, COL_LAST, 8'h00);
        send_command(ACT_WRITE_AT, NEWLINE_CHAR, ROW_LAST, 3, 8'h33);
        send_command(ACT_WRITE_AT, NEWLINE_CHAR, 2, 5, 8'h00);
        send_command(ACT_WRITE_AT, 8'h55, ROW_PAST, 0, 8'h11);
        send_command(ACT_WRITE_AT, 8'h55, 0, COL_PAST, 8'h11);
        send_command(ACT_WRITE_AT, 8'hAA, ROW_TOP, COL_TOP, 8'hAA);
        send_command(ACT_READ, 8'h00, ROW_TOP, COL_TOP, 8'h00);
        send_command(ACT_READ, 8'h00, 0, COL_PAST, 8'h00);
        send_command(ACT_WRITE_AT, 8'hC3, 0, 0, 8'h3C);
        send_command(ACT_WRITE_AT, 8'h01, ROW_LAST, 0, 8'h00);
        send_command(ACT_CLEAR, 8'hFF, ROW_TOP, COL_TOP, 8'hFF);
        send_command(ACT_READ, 8'h00, 0, 0, 8'h00);
        send_command(ACT_READ, 8'h00, ROW_LAST, 0, 8'h00);
        send_command(ACT_WRITE_CURSOR, 8'h20, 0, 0, 8'h00);
    endtask

    task automatic send_sequence();
        int                     kind;
        int                     len;
        logic [ROW_W+COL_W-1:0] spot;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            len = $urandom_range(1, 40);
            repeat (len) send_command(ACT_WRITE_CURSOR, any_byte(), any_row(), any_column(),
                                      pick_attribute());
            send_command(ACT_WRITE_CURSOR, NEWLINE_CHAR, any_row(), any_column(),
                         any_byte());
        end else if (kind < 34) begin
            len = $urandom_range(60, 100);
            repeat (len) send_command(ACT_WRITE_CURSOR, any_byte(), 0, 0,
                                      pick_attribute());
        end else if (kind < 42) begin
            len = $urandom_range(2, 10);
            repeat (len) send_command(ACT_WRITE_CURSOR, NEWLINE_CHAR, 0, 0, any_byte());
        end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_command(ACT_WRITE_AT, pick_glyph(), ROW_LAST, COL_LAST,
                                 pick_attribute());
                end else begin
                    send_command(ACT_WRITE_AT, pick_glyph(), pick_row(), pick_column(),
                                 pick_attribute());
                end
            end
            len = $urandom_range(1, 8);
            repeat (len) begin
                if (written_spots.size() == 0) begin
                    spot = {pick_row(), pick_column()};
                end else begin
                    spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
                end
                send_command(ACT_READ, any_byte(), spot[ROW_W+COL_W-1:COL_W],
                             spot[COL_W-1:0], any_byte());
            end
        end else if (kind < 75) begin
            send_command(ACT_CLEAR, any_byte(), any_row(), any_column(), any_byte());
        end else if (kind < 88) begin
            len = $urandom_range(1, 6);
            repeat (len) send_command(ACT_READ, any_byte(), pick_row(), pick_column(),
                                      any_byte());
        end else begin
            len = $urandom_range(1, 6);
            repeat (len) send_command(2'($urandom_range(0, 3)), any_byte(), any_row(),
                                      any_column(), any_byte());
        end
    endtask

    // Result side: random stalls, a stall-free phase, and one long hold-off.
    initial begin
        i_out_ready   = 1'b0;
        hold_off_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else if (quiet_phase) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                phase;
        int                target;
        logic [ATTR_W-1:0] setting;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_action      = ACT_WRITE_CURSOR;
        i_character   = '0;
        i_row         = '0;
        i_column      = '0;
        i_attribute   = '0;
        quiet_phase   = 1'b0;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_directed();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: setting = 8'h00;
                1: setting = 8'hFF;
                2: setting = 8'h01;
                3: setting = 8'h80;
                default: setting = ATTR_W'($urandom_range(1, 254));
            endcase
            write_default_attribute(setting);
            quiet_phase  = (phase == 1);
            hold_off_req = (phase == 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                send_sequence();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (replies_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && replies_owed == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
